### design/urbc_pkg.sv
// ============================================================================
// urbc_pkg
// types and constants shared by the serial port ring buffer block
// ============================================================================
`default_nettype none

package urbc_pkg;

    localparam int CFG_W  = 7;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] CFG_IDX_BLOCK   = 1'b0;
    localparam logic [IDX_W-1:0] CFG_IDX_RELEASE = 1'b1;

    localparam logic [CFG_W-1:0] CTS_BLOCK_RST   = 7'd10;
    localparam logic [CFG_W-1:0] CTS_RELEASE_RST = 7'd20;

    typedef enum logic [1:0] {
        FUNC_LINE_RX  = 2'd0,
        FUNC_HOST_PUT = 2'd1,
        FUNC_HOST_GET = 2'd2,
        FUNC_TX_READY = 2'd3
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [BYTE_W-1:0] data_byte;
    } in_t;

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] data_out;
        logic              cts_blocked;
        logic              tx_enabled;
        logic              tx_dropped;
    } out_t;

    typedef struct packed {
        logic byte_valid;
        logic sel_tx;
        logic cts_blocked;
        logic tx_enabled;
        logic tx_dropped;
    } pend_t;

endpackage

`default_nettype wire

### design/urbc_ram.sv
// ============================================================================
// urbc_ram
// simple dual port byte memory, one write and one registered read per cycle
// ============================================================================
`default_nettype none

module urbc_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [urbc_pkg::BYTE_W-1:0] wdata,
    input  wire logic                        re,
    input  wire logic [AW-1:0]               raddr,
    output logic      [urbc_pkg::BYTE_W-1:0] rdata
);

    logic [urbc_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/uart_ring_buffers_cts.sv
// ============================================================================
// uart_ring_buffers_cts
// receive and transmit byte rings with cts flow control on the receive side
// ============================================================================
//
//  channel  direction  signals                       beat
//  in       input      in_valid in_ready in_data     one event (func, byte)
//  out      output     out_valid out_ready out_data  one result per event
//  cfg      input      cfg_we cfg_index cfg_wdata    one threshold write
//
//  pointers and flags update at the edge that accepts the beat, the ring is
//  read at that edge, and the result passes from the pending register into
//  the output register once the output is free; one beat per cycle
//  sustained while out_ready stays high
//  reset clears pointers and flags and loads the default thresholds at once; no clearing pass
//  a stalled output holds one result plus one in flight, then in_ready drops
//
`default_nettype none

module uart_ring_buffers_cts #(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire urbc_pkg::in_t                  in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output urbc_pkg::out_t                      out_data,
    input  wire logic                           cfg_we,
    input  wire logic [urbc_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [urbc_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_MW = (RX_AW + 1 > urbc_pkg::CFG_W) ? RX_AW + 1 : urbc_pkg::CFG_W;
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
    localparam logic [RX_AW:0]   RX_SPAN = (RX_AW + 1)'(RX_DEPTH);

    logic [RX_AW-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [TX_AW-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic             cts_reg, cts_next;
    logic             txen_reg, txen_next;
    logic [urbc_pkg::CFG_W-1:0] blk_reg, blk_next, rel_reg, rel_next;

    logic             pend_valid_reg, pend_valid_next;
    urbc_pkg::pend_t  pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    urbc_pkg::out_t   out_reg, out_next;

    logic             in_fire, move;
    logic             rx_we, rx_re, tx_we, tx_re;
    logic [urbc_pkg::BYTE_W-1:0] rx_rdata, tx_rdata;

    logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc;
    logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;
    logic [RX_AW:0]   rx_diff_w, rx_diff_r, rx_fix_w, rx_fix_r;
    logic [RX_MW-1:0] rx_meas_w, rx_meas_r;

    assign rx_wp_inc = (rx_wp_reg == RX_LAST) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RX_LAST) ? '0 : rx_rp_reg + 1'b1;
    assign tx_wp_inc = (tx_wp_reg == TX_LAST) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TX_LAST) ? '0 : tx_rp_reg + 1'b1;

    // free space measure after a line byte and after a host get
    assign rx_diff_w = {1'b0, rx_rp_reg} - {1'b0, rx_wp_inc};
    assign rx_diff_r = {1'b0, rx_rp_inc} - {1'b0, rx_wp_reg};
    assign rx_fix_w  = rx_diff_w[RX_AW] ? rx_diff_w + RX_SPAN : rx_diff_w;
    assign rx_fix_r  = rx_diff_r[RX_AW] ? rx_diff_r + RX_SPAN : rx_diff_r;
    assign rx_meas_w = RX_MW'(rx_fix_w[RX_AW-1:0]);
    assign rx_meas_r = RX_MW'(rx_fix_r[RX_AW-1:0]);

    assign move     = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_valid_reg || move;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        rx_wp_next = rx_wp_reg;
        rx_rp_next = rx_rp_reg;
        tx_wp_next = tx_wp_reg;
        tx_rp_next = tx_rp_reg;
        cts_next   = cts_reg;
        txen_next  = txen_reg;
        rx_we      = 1'b0;
        rx_re      = 1'b0;
        tx_we      = 1'b0;
        tx_re      = 1'b0;
        pend_next  = pend_reg;
        if (in_fire)
        begin
            pend_next = '0;
            case (in_data.func)
                urbc_pkg::FUNC_LINE_RX:
                begin
                    rx_we      = 1'b1;
                    rx_wp_next = rx_wp_inc;
                    if (rx_meas_w < RX_MW'(blk_reg))
                    begin
                        cts_next = 1'b1;
                    end
                end
                urbc_pkg::FUNC_HOST_PUT:
                begin
                    if (tx_wp_inc == tx_rp_reg)
                    begin
                        pend_next.tx_dropped = 1'b1;
                    end
                    else
                    begin
                        tx_we      = 1'b1;
                        tx_wp_next = tx_wp_inc;
                    end
                    txen_next = 1'b1;
                end
                urbc_pkg::FUNC_HOST_GET:
                begin
                    if (rx_rp_reg != rx_wp_reg)
                    begin
                        rx_re                = 1'b1;
                        rx_rp_next           = rx_rp_inc;
                        pend_next.byte_valid = 1'b1;
                        if (rx_meas_r > RX_MW'(rel_reg))
                        begin
                            cts_next = 1'b0;
                        end
                    end
                end
                urbc_pkg::FUNC_TX_READY:
                begin
                    if (tx_rp_reg == tx_wp_reg)
                    begin
                        txen_next = 1'b0;
                    end
                    else
                    begin
                        tx_re                = 1'b1;
                        tx_rp_next           = tx_rp_inc;
                        pend_next.byte_valid = 1'b1;
                        pend_next.sel_tx     = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            pend_next.cts_blocked = cts_next;
            pend_next.tx_enabled  = txen_next;
        end
    end

    always_comb
    begin
        blk_next = blk_reg;
        rel_next = rel_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                urbc_pkg::CFG_IDX_BLOCK:   blk_next = cfg_wdata;
                urbc_pkg::CFG_IDX_RELEASE: rel_next = cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (in_fire)
        begin
            pend_valid_next = 1'b1;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (move)
        begin
            out_valid_next       = 1'b1;
            out_next.byte_valid  = pend_reg.byte_valid;
            out_next.data_out    = '0;
            if (pend_reg.byte_valid)
            begin
                out_next.data_out = pend_reg.sel_tx ? tx_rdata : rx_rdata;
            end
            out_next.cts_blocked = pend_reg.cts_blocked;
            out_next.tx_enabled  = pend_reg.tx_enabled;
            out_next.tx_dropped  = pend_reg.tx_dropped;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wp_reg      <= '0;
            rx_rp_reg      <= '0;
            tx_wp_reg      <= '0;
            tx_rp_reg      <= '0;
            cts_reg        <= 1'b0;
            txen_reg       <= 1'b0;
            blk_reg        <= urbc_pkg::CTS_BLOCK_RST;
            rel_reg        <= urbc_pkg::CTS_RELEASE_RST;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rx_wp_reg      <= rx_wp_next;
            rx_rp_reg      <= rx_rp_next;
            tx_wp_reg      <= tx_wp_next;
            tx_rp_reg      <= tx_rp_next;
            cts_reg        <= cts_next;
            txen_reg       <= txen_next;
            blk_reg        <= blk_next;
            rel_reg        <= rel_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    urbc_ram #(
        .DEPTH (RX_DEPTH),
        .AW    (RX_AW)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wp_reg),
        .wdata (in_data.data_byte),
        .re    (rx_re),
        .raddr (rx_rp_reg),
        .rdata (rx_rdata)
    );

    urbc_ram #(
        .DEPTH (TX_DEPTH),
        .AW    (TX_AW)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wp_reg),
        .wdata (in_data.data_byte),
        .re    (tx_re),
        .raddr (tx_rp_reg),
        .rdata (tx_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_pend_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("pending result not moved to output register");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("beat accepted while result path is full");

    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.byte_valid |-> out_reg.data_out == '0)
        else $error("data_out not zero without a byte");

    a_drop_keeps_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.tx_dropped |-> out_reg.tx_enabled)
        else $error("dropped put without transmit enable");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (RX_AW + 1)'(rx_wp_reg) < RX_SPAN && (RX_AW + 1)'(rx_rp_reg) < RX_SPAN)
        else $error("receive pointer out of range");
`endif

endmodule

`default_nettype wire

### tb/tb_uart_ring_buffers_cts.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_uart_ring_buffers_cts
// self-checking bench for the serial port receive/transmit rings with cts
// ----------------------------------------------------------------------------
// a queue of events feeds a valid/ready driver; every accepted event runs
// through a bench-side model of both rings, the cts flag and the transmit
// enable, and the expected result is queued. the monitor compares each output
// beat field by field. thresholds are rewritten between drained phases,
// extremes included. both sides idle in random bursts, and the receiver
// holds off for long stretches so the block backs up into its input.
// ============================================================================

module tb_uart_ring_buffers_cts;

    localparam int RX_SLOTS   = 128;
    localparam int TX_SLOTS   = 256;
    localparam int RX_PTR_W   = $clog2(RX_SLOTS);
    localparam int TX_PTR_W   = $clog2(TX_SLOTS);
    localparam int LONG_HOLD  = 300;
    localparam int HOLD_EVERY = 500;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    urbc_pkg::in_t                      in_data   = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    urbc_pkg::out_t                     out_data;
    logic                               cfg_we    = 1'b0;
    logic [urbc_pkg::IDX_W-1:0]         cfg_index = '0;
    logic [urbc_pkg::CFG_W-1:0]         cfg_wdata = '0;
    logic                               quiet     = 1'b0;

    // bench copy of the block state
    logic [urbc_pkg::BYTE_W-1:0]        rx_ring [0:RX_SLOTS-1];
    logic [urbc_pkg::BYTE_W-1:0]        tx_ring [0:TX_SLOTS-1];
    logic [RX_PTR_W-1:0]                rx_wr     = '0;
    logic [RX_PTR_W-1:0]                rx_rd     = '0;
    logic [TX_PTR_W-1:0]                tx_wr     = '0;
    logic [TX_PTR_W-1:0]                tx_rd     = '0;
    logic                               cts_state = 1'b0;
    logic                               txen_state = 1'b0;
    logic [urbc_pkg::CFG_W-1:0]         block_thr = urbc_pkg::CTS_BLOCK_RST;
    logic [urbc_pkg::CFG_W-1:0]         rel_thr   = urbc_pkg::CTS_RELEASE_RST;

    urbc_pkg::in_t       pending_events [$];
    urbc_pkg::out_t      expected_results [$];
    int                  fails      = 0;
    int                  send_gap   = 0;
    int                  stall_left = 0;
    int                  hold_left  = 0;
    int                  hold_mark  = 400;
    int                  beats_seen = 0;

    uart_ring_buffers_cts #(
        .RX_DEPTH (RX_SLOTS),
        .TX_DEPTH (TX_SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic urbc_pkg::out_t predict_event(input urbc_pkg::in_t ev);
        urbc_pkg::out_t      r;
        logic [RX_PTR_W-1:0] rx_gap;
        r = '0;
        case (ev.func)
            urbc_pkg::FUNC_LINE_RX:
            begin
                rx_ring[rx_wr] = ev.data_byte;
                rx_wr = rx_wr + 1'b1;
                rx_gap = rx_rd - rx_wr;
                if (rx_gap < block_thr)
                    cts_state = 1'b1;
            end
            urbc_pkg::FUNC_HOST_PUT:
            begin
                tx_ring[tx_wr] = ev.data_byte;
                tx_wr = tx_wr + 1'b1;
                if (tx_wr == tx_rd)
                begin
                    tx_wr = tx_wr - 1'b1;
                    r.tx_dropped = 1'b1;
                end
                txen_state = 1'b1;
            end
            urbc_pkg::FUNC_HOST_GET:
            begin
                if (rx_rd != rx_wr)
                begin
                    r.data_out = rx_ring[rx_rd];
                    r.byte_valid = 1'b1;
                    rx_rd = rx_rd + 1'b1;
                    rx_gap = rx_rd - rx_wr;
                    if (rx_gap > rel_thr)
                        cts_state = 1'b0;
                end
            end
            default:
            begin
                if (tx_rd == tx_wr)
                    txen_state = 1'b0;
                else
                begin
                    r.data_out = tx_ring[tx_rd];
                    r.byte_valid = 1'b1;
                    tx_rd = tx_rd + 1'b1;
                end
            end
        endcase
        r.cts_blocked = cts_state;
        r.tx_enabled = txen_state;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    // driver: threshold writes, prediction at accept, next beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == urbc_pkg::CFG_IDX_BLOCK)
                    block_thr = cfg_wdata;
                else
                    rel_thr = cfg_wdata;
            end
            if (in_valid && in_ready)
                expected_results.push_back(predict_event(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_events.size() != 0)
                begin
                    if (!quiet && $urandom_range(0, 9) == 0)
                    begin
                        in_valid <= 1'b0;
                        send_gap <= $urandom_range(0, 15);
                    end
                    else
                    begin
                        in_valid <= 1'b1;
                        in_data <= pending_events.pop_front();
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result beat, drive out_ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                beats_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing pending: 0x%0h", out_data);
                    fails++;
                end
                else
                begin
                    urbc_pkg::out_t want;
                    want = expected_results.pop_front();
                    check_field("byte_valid", 8'(want.byte_valid),
                                8'(out_data.byte_valid));
                    check_field("data_out", want.data_out, out_data.data_out);
                    check_field("cts_blocked", 8'(want.cts_blocked),
                                8'(out_data.cts_blocked));
                    check_field("tx_enabled", 8'(want.tx_enabled),
                                8'(out_data.tx_enabled));
                    check_field("tx_dropped", 8'(want.tx_dropped),
                                8'(out_data.tx_dropped));
                end
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (!quiet && beats_seen >= hold_mark)
            begin
                // long back-pressure so in_ready drops
                out_ready <= 1'b0;
                hold_left <= LONG_HOLD;
                hold_mark <= hold_mark + HOLD_EVERY;
            end
            else if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                out_ready <= 1'b0;
                stall_left <= $urandom_range(0, 15);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic push_event(input urbc_pkg::func_t f,
                              input logic [urbc_pkg::BYTE_W-1:0] b);
        urbc_pkg::in_t ev;
        ev.func = f;
        ev.data_byte = b;
        pending_events.push_back(ev);
    endtask

    task automatic push_run(input urbc_pkg::func_t f, input int len);
        for (int i = 0; i < len; i++)
            push_event(f, urbc_pkg::BYTE_W'($urandom));
    endtask

    task automatic gen_random(input int n);
        int made;
        int len;
        int kind;
        made = 0;
        while (made < n)
        begin
            kind = $urandom_range(0, 9);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 140)
                                                : $urandom_range(1, 30);
            case (kind)
                0, 1: push_run(urbc_pkg::FUNC_LINE_RX, len);
                2, 3: push_run(urbc_pkg::FUNC_HOST_GET, len);
                4:
                begin
                    len = $urandom_range(1, 30);
                    push_run(urbc_pkg::FUNC_HOST_PUT, len);
                end
                5:
                begin
                    len = $urandom_range(1, 30);
                    push_run(urbc_pkg::FUNC_TX_READY, len);
                end
                default:
                begin
                    // noise: any event, any byte
                    len = $urandom_range(1, 20);
                    for (int i = 0; i < len; i++)
                        push_event(urbc_pkg::func_t'($urandom_range(0, 3)),
                                   urbc_pkg::BYTE_W'($urandom));
                end
            endcase
            made += len;
        end
    endtask

    task automatic wait_drained;
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_thresholds(input logic [urbc_pkg::CFG_W-1:0] blk,
                                  input logic [urbc_pkg::CFG_W-1:0] rel);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= urbc_pkg::CFG_IDX_BLOCK;
        cfg_wdata <= blk;
        @(posedge clk);
        cfg_index <= urbc_pkg::CFG_IDX_RELEASE;
        cfg_wdata <= rel;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty rings, disabled transmitter, byte extremes
        push_event(urbc_pkg::FUNC_HOST_GET, 8'h00);
        push_event(urbc_pkg::FUNC_TX_READY, 8'hFF);
        push_event(urbc_pkg::FUNC_LINE_RX, 8'h00);
        push_event(urbc_pkg::FUNC_LINE_RX, 8'hFF);
        push_event(urbc_pkg::FUNC_LINE_RX, 8'hA5);
        push_event(urbc_pkg::FUNC_HOST_GET, 8'hFF);
        push_event(urbc_pkg::FUNC_HOST_GET, 8'h00);
        push_event(urbc_pkg::FUNC_HOST_GET, 8'h00);
        push_event(urbc_pkg::FUNC_HOST_GET, 8'hFF);
        push_event(urbc_pkg::FUNC_HOST_PUT, 8'h00);
        push_event(urbc_pkg::FUNC_HOST_PUT, 8'hFF);
        push_event(urbc_pkg::FUNC_HOST_PUT, 8'h5A);
        push_event(urbc_pkg::FUNC_TX_READY, 8'h00);
        push_event(urbc_pkg::FUNC_TX_READY, 8'h00);
        push_event(urbc_pkg::FUNC_TX_READY, 8'h00);
        push_event(urbc_pkg::FUNC_TX_READY, 8'h00);
        push_event(urbc_pkg::FUNC_TX_READY, 8'hFF);
        push_event(urbc_pkg::FUNC_LINE_RX, 8'h5A);
        push_event(urbc_pkg::FUNC_HOST_PUT, 8'hC3);
        push_event(urbc_pkg::FUNC_HOST_GET, 8'h3C);
        push_event(urbc_pkg::FUNC_TX_READY, 8'h96);
        push_event(urbc_pkg::FUNC_TX_READY, 8'h69);
        wait_drained();

        set_thresholds(7'd127, 7'd0);
        gen_random(250);
        wait_drained();

        set_thresholds(7'd0, 7'd127);
        gen_random(200);
        wait_drained();

        // fill the transmit ring past full, then drain it dry
        set_thresholds(urbc_pkg::CFG_W'($urandom), urbc_pkg::CFG_W'($urandom));
        push_run(urbc_pkg::FUNC_HOST_PUT, TX_SLOTS + 2);
        push_run(urbc_pkg::FUNC_TX_READY, TX_SLOTS + 4);
        gen_random(100);
        wait_drained();

        quiet <= 1'b1;
        set_thresholds(urbc_pkg::CTS_BLOCK_RST, urbc_pkg::CTS_RELEASE_RST);
        gen_random(200);
        wait_drained();
        repeat (10) @(negedge clk);

        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
design/urbc_pkg.sv
design/urbc_ram.sv
design/uart_ring_buffers_cts.sv
tb/tb_uart_ring_buffers_cts.sv
